// File: rtl/afc_pkg.sv
package afc_pkg;

    // Number of planes tested for each item, and number of writable plane registers.
    localparam int NUM_PLANES  = 6;
    localparam int PLANE_REGS  = 6;
    localparam int NUM_AXES    = 3;

    // Configuration port geometry.
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // Fixed-point widths.
    localparam int COORD_W     = 24;                    // Q15.8 input coordinate
    localparam int CORNER_W    = COORD_W + 1;           // box plus position, Q16.8
    localparam int NORM_W      = 12;                    // Q1.10 normal component
    localparam int CONST_W     = 28;                    // Q19.8 plane constant
    localparam int CONST_LSB   = NORM_W * NUM_AXES;     // constant field position
    localparam int CONST_SHIFT = 10;                    // Q.8 to Q.18 alignment
    localparam int PROD_W      = NORM_W + CORNER_W;     // one normal times coordinate
    localparam int DIST_W      = PROD_W + 3;            // room for three products and constant

    typedef logic [CFG_DATA_W-1:0] t_plane;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [CORNER_W-1:0] t_corner;
    typedef logic signed [NORM_W-1:0] t_norm;
    typedef logic signed [CONST_W-1:0] t_const;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [DIST_W-1:0] t_dist;

    // Normal component of one axis from a packed plane word.
    function automatic t_norm plane_normal(input t_plane p, input logic [1:0] axis);
        t_norm n;
        case (axis)
            2'd0:    n = t_norm'(p[NORM_W-1:0]);
            2'd1:    n = t_norm'(p[2*NORM_W-1:NORM_W]);
            2'd2:    n = t_norm'(p[3*NORM_W-1:2*NORM_W]);
            default: n = '0;
        endcase
        return n;
    endfunction

    // Plane constant from a packed plane word.
    function automatic t_const plane_const(input t_plane p);
        return t_const'(p[CONST_LSB+CONST_W-1:CONST_LSB]);
    endfunction

endpackage

// File: rtl/afc_product.sv
module afc_product (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  afc_pkg::t_corner      i_lo [afc_pkg::NUM_AXES],
    input  afc_pkg::t_corner      i_hi [afc_pkg::NUM_AXES],
    input  afc_pkg::t_plane       i_plane [afc_pkg::NUM_PLANES],
    output afc_pkg::t_prod        o_prod [afc_pkg::NUM_PLANES][afc_pkg::NUM_AXES]
);

    afc_pkg::t_prod r_prod [afc_pkg::NUM_PLANES][afc_pkg::NUM_AXES];
    afc_pkg::t_prod n_prod [afc_pkg::NUM_PLANES][afc_pkg::NUM_AXES];

    // Pick the positive vertex per axis and multiply it by the normal component.
    // A zero component counts as non-negative, so the maximum is used.
    always_comb begin
        afc_pkg::t_norm   v_n;
        afc_pkg::t_corner v_c;
        for (int k = 0; k < afc_pkg::NUM_PLANES; k++) begin
            for (int a = 0; a < afc_pkg::NUM_AXES; a++) begin
                v_n = afc_pkg::plane_normal(i_plane[k], 2'(a));
                v_c = v_n[afc_pkg::NORM_W-1] ? i_lo[a] : i_hi[a];
                n_prod[k][a] = afc_pkg::t_prod'(v_n) * afc_pkg::t_prod'(v_c);
            end
        end
    end

    // Product register; no reset needed for payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/afc_decide.sv
module afc_decide (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  afc_pkg::t_prod        i_prod [afc_pkg::NUM_PLANES][afc_pkg::NUM_AXES],
    input  afc_pkg::t_plane       i_plane [afc_pkg::NUM_PLANES],
    output logic                  o_culled
);

    logic r_culled;
    logic n_culled;

    // Signed distance of the positive vertex for each plane; negative means behind.
    always_comb begin
        afc_pkg::t_dist v_dist;
        n_culled = 1'b0;
        for (int k = 0; k < afc_pkg::NUM_PLANES; k++) begin
            v_dist = (afc_pkg::t_dist'(afc_pkg::plane_const(i_plane[k]))
                      <<< afc_pkg::CONST_SHIFT)
                   + afc_pkg::t_dist'(i_prod[k][0])
                   + afc_pkg::t_dist'(i_prod[k][1])
                   + afc_pkg::t_dist'(i_prod[k][2]);
            n_culled = n_culled | v_dist[afc_pkg::DIST_W-1];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_culled <= n_culled;
        end
    end

    assign o_culled = r_culled;

endmodule

// File: rtl/aabb_frustum_cull_test_core.sv
// Channel   Direction  Handshake             Payload
// input     in         i_valid / o_ready     i_pos_*, i_box_min_*, i_box_max_* (24-bit signed)
// output    out        o_valid / i_ready     o_culled (1 bit)
// config    in         i_cfg_we              i_cfg_idx (3 bits), i_cfg_data (64 bits)
//
// Three register stages: input register, product register, result register.
// One item is accepted every cycle while the output is not stalled; its result
// passes the product and result registers and is held on o_culled until taken.
// One item per cycle holds because no stage holds an item back for extra work.
// A stalled output holds its result while earlier stages keep filling behind it.
// Synchronous active-low reset empties the pipeline and clears all planes to zero.
module aabb_frustum_cull_test_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  afc_pkg::t_coord            i_pos_x,
    input  afc_pkg::t_coord            i_pos_y,
    input  afc_pkg::t_coord            i_pos_z,
    input  afc_pkg::t_coord            i_box_min_x,
    input  afc_pkg::t_coord            i_box_min_y,
    input  afc_pkg::t_coord            i_box_min_z,
    input  afc_pkg::t_coord            i_box_max_x,
    input  afc_pkg::t_coord            i_box_max_y,
    input  afc_pkg::t_coord            i_box_max_z,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_culled,
    input  logic                       i_cfg_we,
    input  logic [afc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [afc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    afc_pkg::t_plane  r_plane [afc_pkg::PLANE_REGS];
    afc_pkg::t_plane  w_plane [afc_pkg::NUM_PLANES];
    afc_pkg::t_corner r_lo [afc_pkg::NUM_AXES];
    afc_pkg::t_corner r_hi [afc_pkg::NUM_AXES];
    afc_pkg::t_corner n_lo [afc_pkg::NUM_AXES];
    afc_pkg::t_corner n_hi [afc_pkg::NUM_AXES];
    afc_pkg::t_prod   w_prod [afc_pkg::NUM_PLANES][afc_pkg::NUM_AXES];
    logic             r_v0;
    logic             r_v1;
    logic             r_v2;
    logic             w_adv0;
    logic             w_adv1;
    logic             w_adv2;

    // Plane registers; writes to an index past the last plane are dropped.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < afc_pkg::PLANE_REGS; k++) begin
            if (!i_rst_n) begin
                r_plane[k] <= '0;
            end else if (i_cfg_we && (i_cfg_idx == afc_pkg::CFG_IDX_W'(k))) begin
                r_plane[k] <= i_cfg_data;
            end
        end
    end

    // Planes beyond the writable set read as zero and never cull.
    for (genvar k = 0; k < afc_pkg::NUM_PLANES; k++) begin : g_plane
        if (k < afc_pkg::PLANE_REGS) begin : g_reg
            assign w_plane[k] = r_plane[k];
        end else begin : g_zero
            assign w_plane[k] = '0;
        end
    end

    // Stall logic: each stage moves when it is empty or the next stage moves.
    assign w_adv2  = !r_v2 || i_ready;
    assign w_adv1  = !r_v1 || w_adv2;
    assign w_adv0  = !r_v0 || w_adv1;
    assign o_ready = w_adv0;
    assign o_valid = r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv0) begin
                r_v0 <= i_valid;
            end
            if (w_adv1) begin
                r_v1 <= r_v0;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // World-space box corners, one bit wider than the inputs so the sum is exact.
    always_comb begin
        n_lo[0] = afc_pkg::t_corner'(i_box_min_x) + afc_pkg::t_corner'(i_pos_x);
        n_lo[1] = afc_pkg::t_corner'(i_box_min_y) + afc_pkg::t_corner'(i_pos_y);
        n_lo[2] = afc_pkg::t_corner'(i_box_min_z) + afc_pkg::t_corner'(i_pos_z);
        n_hi[0] = afc_pkg::t_corner'(i_box_max_x) + afc_pkg::t_corner'(i_pos_x);
        n_hi[1] = afc_pkg::t_corner'(i_box_max_y) + afc_pkg::t_corner'(i_pos_y);
        n_hi[2] = afc_pkg::t_corner'(i_box_max_z) + afc_pkg::t_corner'(i_pos_z);
    end

    // Input register holds the corners of the accepted item.
    always_ff @(posedge i_clk) begin
        if (w_adv0) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    afc_product u_product (
        .i_clk   (i_clk),
        .i_en    (w_adv1),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .i_plane (w_plane),
        .o_prod  (w_prod)
    );

    afc_decide u_decide (
        .i_clk    (i_clk),
        .i_en     (w_adv2),
        .i_prod   (w_prod),
        .i_plane  (w_plane),
        .o_culled (o_culled)
    );

endmodule

// File: bench/afc_cull_checker.sv
// Watches the object and verdict channels of the frustum cull core, keeps its
// own copy of the plane registers, predicts the culled flag of every accepted
// object and compares it with the verdict items in order.
module afc_cull_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  afc_pkg::t_coord                 i_pos_x,
    input  afc_pkg::t_coord                 i_pos_y,
    input  afc_pkg::t_coord                 i_pos_z,
    input  afc_pkg::t_coord                 i_box_min_x,
    input  afc_pkg::t_coord                 i_box_min_y,
    input  afc_pkg::t_coord                 i_box_min_z,
    input  afc_pkg::t_coord                 i_box_max_x,
    input  afc_pkg::t_coord                 i_box_max_y,
    input  afc_pkg::t_coord                 i_box_max_z,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_culled,
    input  logic                            i_cfg_we,
    input  logic [afc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [afc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_mismatches,
    output int                              o_pending
);

    localparam int PLANE_SLOTS = 2 ** afc_pkg::CFG_IDX_W;

    typedef longint t_span [afc_pkg::NUM_AXES];

    afc_pkg::t_plane plane_store [PLANE_SLOTS];
    bit              culls_due [$];

    // True when the positive vertex of the box lies strictly behind the plane.
    function automatic bit vertex_behind(input afc_pkg::t_plane p, input t_span lo,
                                         input t_span hi);
        afc_pkg::t_norm  n;
        afc_pkg::t_const k;
        longint          distance;
        longint          corner;
        k        = p[afc_pkg::CONST_LSB +: afc_pkg::CONST_W];
        distance = longint'(k) * (longint'(1) << afc_pkg::CONST_SHIFT);
        for (int a = 0; a < afc_pkg::NUM_AXES; a++) begin
            n        = p[afc_pkg::NORM_W * a +: afc_pkg::NORM_W];
            corner   = (n < 0) ? lo[a] : hi[a];
            distance = distance + longint'(n) * corner;
        end
        return distance < 0;
    endfunction

    always @(posedge i_clk) begin
        t_span lo;
        t_span hi;
        bit    cull;
        bit    want;
        if (!i_rst_n) begin
            foreach (plane_store[k]) plane_store[k] = '0;
            culls_due.delete();
        end else begin
            // A delivered verdict item is matched against the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (culls_due.size() == 0) begin
                    $error("culled: expected nothing, actual %0d", i_culled);
                    o_mismatches++;
                end else begin
                    want = culls_due.pop_front();
                    if (i_culled !== want) begin
                        $error("culled: expected %0d, actual %0d", want, i_culled);
                        o_mismatches++;
                    end
                end
            end

            // Offset the box by the position and test it against every active plane.
            if (i_in_valid && i_in_ready) begin
                lo[0] = longint'(i_box_min_x) + longint'(i_pos_x);
                lo[1] = longint'(i_box_min_y) + longint'(i_pos_y);
                lo[2] = longint'(i_box_min_z) + longint'(i_pos_z);
                hi[0] = longint'(i_box_max_x) + longint'(i_pos_x);
                hi[1] = longint'(i_box_max_y) + longint'(i_pos_y);
                hi[2] = longint'(i_box_max_z) + longint'(i_pos_z);
                cull  = 1'b0;
                for (int k = 0; k < afc_pkg::NUM_PLANES && k < PLANE_SLOTS; k++) begin
                    if (vertex_behind(plane_store[k], lo, hi)) cull = 1'b1;
                end
                culls_due.push_back(cull);
            end

            // Only the real plane registers take writes.
            if (i_cfg_we && i_cfg_idx < afc_pkg::PLANE_REGS) begin
                plane_store[i_cfg_idx] = i_cfg_data;
            end
        end
        o_pending = culls_due.size();
    end

endmodule

// File: bench/aabb_frustum_cull_test_core_tb.sv
// Drives object items and plane registers into the cull core with random gaps
// and stalls on both channels; the checker beside the core judges each verdict.
module aabb_frustum_cull_test_core_tb;

    localparam int PIPE_DEPTH      = 3;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int RUN_LIMIT       = 1_500_000;

    localparam afc_pkg::t_coord C_MAX = afc_pkg::t_coord'(24'h7FFFFF);
    localparam afc_pkg::t_coord C_MIN = afc_pkg::t_coord'(24'h800000);
    localparam afc_pkg::t_norm  N_MAX = afc_pkg::t_norm'(12'h7FF);
    localparam afc_pkg::t_norm  N_MIN = afc_pkg::t_norm'(12'h800);
    localparam afc_pkg::t_const K_MAX = afc_pkg::t_const'(28'h7FFFFFF);
    localparam afc_pkg::t_const K_MIN = afc_pkg::t_const'(28'h8000000);

    typedef enum logic [afc_pkg::CFG_IDX_W-1:0] {
        REG_PLANE_0, REG_PLANE_1, REG_PLANE_2, REG_PLANE_3,
        REG_PLANE_4, REG_PLANE_5, REG_SPARE_6, REG_SPARE_7
    } t_reg_idx;

    typedef struct packed {
        afc_pkg::t_coord pos_x;
        afc_pkg::t_coord pos_y;
        afc_pkg::t_coord pos_z;
        afc_pkg::t_coord box_min_x;
        afc_pkg::t_coord box_min_y;
        afc_pkg::t_coord box_min_z;
        afc_pkg::t_coord box_max_x;
        afc_pkg::t_coord box_max_y;
        afc_pkg::t_coord box_max_z;
    } t_object;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    t_object                         obj;
    logic                            out_valid;
    logic                            out_ready;
    logic                            culled;
    logic                            cfg_we;
    t_reg_idx                        cfg_idx;
    logic [afc_pkg::CFG_DATA_W-1:0]  cfg_data;
    int                              mismatches;
    int                              pending;
    bit                              gapless;

    aabb_frustum_cull_test_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_pos_x     (obj.pos_x),
        .i_pos_y     (obj.pos_y),
        .i_pos_z     (obj.pos_z),
        .i_box_min_x (obj.box_min_x),
        .i_box_min_y (obj.box_min_y),
        .i_box_min_z (obj.box_min_z),
        .i_box_max_x (obj.box_max_x),
        .i_box_max_y (obj.box_max_y),
        .i_box_max_z (obj.box_max_z),
        .o_valid     (out_valid),
        .i_ready     (out_ready),
        .o_culled    (culled),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    afc_cull_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_pos_x      (obj.pos_x),
        .i_pos_y      (obj.pos_y),
        .i_pos_z      (obj.pos_z),
        .i_box_min_x  (obj.box_min_x),
        .i_box_min_y  (obj.box_min_y),
        .i_box_min_z  (obj.box_min_z),
        .i_box_max_x  (obj.box_max_x),
        .i_box_max_y  (obj.box_max_y),
        .i_box_max_z  (obj.box_max_z),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_culled     (culled),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Hard stop in case the core hangs.
    initial begin
        #(RUN_LIMIT);
        $display("aabb_frustum_cull_test_core: mismatch");
        $finish;
    end

    // Verdict side: stall a random number of cycles before taking each item.
    initial begin
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            gap = gapless ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic afc_pkg::t_plane make_plane(input afc_pkg::t_norm nx,
                                                   input afc_pkg::t_norm ny,
                                                   input afc_pkg::t_norm nz,
                                                   input afc_pkg::t_const k);
        return {k, nz, ny, nx};
    endfunction

    // Random signed value that fits in w bits.
    function automatic afc_pkg::t_coord rand_coord(input int w);
        logic [afc_pkg::COORD_W-1:0] raw;
        logic [afc_pkg::COORD_W-1:0] mask;
        raw = afc_pkg::COORD_W'($urandom);
        if (w >= afc_pkg::COORD_W) return raw;
        mask = (afc_pkg::COORD_W'(1) << w) - 1'b1;
        raw  = raw & mask;
        if (raw[w-1]) raw = raw | ~mask;
        return raw;
    endfunction

    // Present one object item after a random gap and hold it until accepted.
    task automatic send_object(input t_object b);
        int gap;
        gap = gapless ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        obj      <= b;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(input t_reg_idx r, input afc_pkg::t_plane v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= r;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Stop sending and wait until every verdict has come back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (PIPE_DEPTH + 2) @(negedge clk);
    endtask

    initial begin
        t_object         extreme_objs [4];
        t_object         hand_objs [9];
        t_object         b;
        afc_pkg::t_coord p [3];
        afc_pkg::t_coord lo [3];
        afc_pkg::t_coord hi [3];
        afc_pkg::t_coord c;
        afc_pkg::t_coord e;
        afc_pkg::t_plane pl;
        int              s;
        int              kind;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        obj      = '0;
        cfg_we   = 1'b0;
        cfg_idx  = REG_PLANE_0;
        cfg_data = '0;
        gapless  = 1'b0;

        extreme_objs = '{
            '{0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX},
            '{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN},
            '{C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX}
        };

        // Boxes placed right at and just past the hand-built planes below.
        hand_objs = '{
            '{5, 0, 0, -10, -3, -1, -5, 3, 1},
            '{5, 0, 0, -10, -3, -1, -6, 3, 1},
            '{0, 4, 0, -1, -3, -1, 1, 10, 1},
            '{0, 4, 0, -1, -4, -1, 1, 10, 1},
            '{0, 0, 150, -1, -1, 50, 1, 1, 300},
            '{0, 0, 150, -1, -1, 51, 1, 1, 300},
            '{0, 0, 0, 10, -1, -1, -10, 1, 1},
            '{0, 0, 0, -1, 5, -1, 1, -5, 1},
            '{0, 0, 0, 20, -1, -1, 1, 1, 1}
        };

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Planes straight out of reset are all zero, so nothing gets culled.
        foreach (extreme_objs[i]) send_object(extreme_objs[i]);
        drain();

        // Writes beyond the last plane must not land anywhere.
        write_reg(REG_SPARE_6, make_plane(0, 0, 0, K_MIN));
        write_reg(REG_SPARE_7, '1);
        foreach (extreme_objs[i]) send_object(extreme_objs[i]);
        drain();

        // Two axis planes through the origin, one offset plane and one constant-only plane,
        // giving exact zero distances that must not cull, and inverted boxes.
        write_reg(REG_PLANE_0, make_plane(1024, 0, 0, 0));
        write_reg(REG_PLANE_1, make_plane(0, -1024, 0, 0));
        write_reg(REG_PLANE_2, make_plane(0, 0, 0, 1));
        write_reg(REG_PLANE_3, make_plane(0, 0, -512, 100));
        write_reg(REG_PLANE_4, '0);
        write_reg(REG_PLANE_5, '0);
        foreach (hand_objs[i]) send_object(hand_objs[i]);
        drain();

        // All-ones planes, then alternating most negative and most positive planes.
        for (int k = 0; k < afc_pkg::PLANE_REGS; k++) write_reg(t_reg_idx'(k), '1);
        foreach (extreme_objs[i]) send_object(extreme_objs[i]);
        drain();
        for (int k = 0; k < afc_pkg::PLANE_REGS; k++) begin
            write_reg(t_reg_idx'(k), (k % 2 == 0) ? make_plane(N_MIN, N_MIN, N_MIN, K_MIN)
                                                  : make_plane(N_MAX, N_MAX, N_MAX, K_MAX));
        end
        foreach (extreme_objs[i]) send_object(extreme_objs[i]);
        drain();

        // Random phases: new planes, mostly at a scale matched to the boxes, then a
        // stream of mostly well-formed boxes with some inverted ones and noise.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            gapless = (ph % 3 == 1);
            s       = $urandom_range(2, 23);
            for (int k = 0; k < afc_pkg::PLANE_REGS; k++) begin
                if (ph % 4 == 0) begin
                    pl = {$urandom, $urandom};
                end else if ($urandom_range(0, 2) == 0) begin
                    pl = '0;
                end else begin
                    pl = make_plane(afc_pkg::t_norm'($urandom), afc_pkg::t_norm'($urandom),
                                    afc_pkg::t_norm'($urandom),
                                    afc_pkg::t_const'(rand_coord(s)));
                end
                write_reg(t_reg_idx'(k), pl);
            end
            if ($urandom_range(0, 1) == 1) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                          {$urandom, $urandom});
            end

            repeat (ITEMS_PER_PHASE) begin
                kind = $urandom_range(0, 9);
                for (int a = 0; a < 3; a++) begin
                    p[a]  = rand_coord(s);
                    c     = rand_coord(s - 1);
                    e     = rand_coord(s - 1) & ((afc_pkg::COORD_W'(1) << (s - 1)) - 1'b1);
                    lo[a] = c - e;
                    hi[a] = c + e;
                    if (kind == 1) begin
                        lo[a] = c + e;
                        hi[a] = c - e;
                    end
                end
                if (kind == 0) begin
                    b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         afc_pkg::COORD_W'($urandom)};
                end else begin
                    b = '{p[0], p[1], p[2], lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
                end
                send_object(b);
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("aabb_frustum_cull_test_core: match");
        end else begin
            $display("aabb_frustum_cull_test_core: mismatch");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/afc_pkg.sv
rtl/afc_product.sv
rtl/afc_decide.sv
rtl/aabb_frustum_cull_test_core.sv
bench/afc_cull_checker.sv
bench/aabb_frustum_cull_test_core_tb.sv
